FILE: sv/iib_pkg.sv
// Shared constants for the integral image builder: field widths,
// configuration register indexes and their reset values. No dependencies.
`default_nettype none

package iib_pkg;

  // Field widths of the streaming channels.
  localparam int unsigned PIX_W = 8;
  localparam int unsigned SUM_W = 28;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CHN_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST   = 11'd640;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST  = 11'd480;
  localparam logic [CHN_W-1:0] CHANNEL_COUNT_RST = 3'd3;

endpackage : iib_pkg

`default_nettype wire

FILE: sv/integral_image_builder_core.sv
// Top level of the streaming integral image (summed-area table) builder.
// Uses iib_pkg and the line store iib_line_ram.
`default_nettype none

//  Channel   Ports                                   Direction
//  ------    --------------------------------------  ---------
//  input     in_valid, in_stall, in_pixel_value,     in
//            in_frame_start
//  result    out_valid, out_stall, out_area_sum,     out
//            out_frame_end
//  config    cfg_wr_en, cfg_index, cfg_wdata         in
//
// One byte is taken per cycle while in_stall is low; each result passes via
// the summing stage and the output register. The throughput is set by the
// line store, which takes one read and one write per cycle. Reset clears
// positions, row sums and the pipeline; the line store needs no clearing
// because row 0 never uses it. A stall on the result side backs up into
// in_stall only when both the output register and the summing stage are full.
module integral_image_builder_core
  import iib_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      in_pixel_value,
  input  wire logic                  in_frame_start,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [SUM_W-1:0]      out_area_sum,
  output logic                       out_frame_end,
  // Configuration port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // A row sum of one channel is at most MAX_WIDTH * 255.
  localparam int unsigned RS_W   = $clog2(MAX_WIDTH) + PIX_W;
  localparam int unsigned WL_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HL_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CL_W   = $clog2(MAX_CHANNELS + 1);

  // ---------------------------------------------------------------------
  // Configuration registers and their effective limits.
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0] cfg_width_r;
  logic [DIM_W-1:0] cfg_height_r;
  logic [CHN_W-1:0] cfg_chan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= IMAGE_WIDTH_RST;
      cfg_height_r <= IMAGE_HEIGHT_RST;
      cfg_chan_r   <= CHANNEL_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   cfg_width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  cfg_height_r <= cfg_wdata[DIM_W-1:0];
        CFG_CHANNEL_COUNT: cfg_chan_r   <= cfg_wdata[CHN_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero register acts as one; a value above the maximum acts as the maximum.
  logic [WL_W-1:0] w_lim;
  logic [HL_W-1:0] h_lim;
  logic [CL_W-1:0] nc_lim;

  always_comb begin
    if (cfg_width_r == '0) begin
      w_lim = WL_W'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_lim = WL_W'(MAX_WIDTH);
    end else begin
      w_lim = WL_W'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_lim = HL_W'(1);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      h_lim = HL_W'(MAX_HEIGHT);
    end else begin
      h_lim = HL_W'(cfg_height_r);
    end
    if (cfg_chan_r == '0) begin
      nc_lim = CL_W'(1);
    end else if (32'(cfg_chan_r) > 32'(MAX_CHANNELS)) begin
      nc_lim = CL_W'(MAX_CHANNELS);
    end else begin
      nc_lim = CL_W'(cfg_chan_r);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake. Stage A is the accept edge, stage B adds the line
  // entry and writes it back while loading the output register.
  // ---------------------------------------------------------------------
  logic                 s1_valid_r;
  logic [ADDR_W-1:0]    s1_addr_r;
  logic [RS_W-1:0]      s1_rowsum_r;
  logic                 s1_row0_r;
  logic                 s1_last_r;
  logic                 fwd_r;
  logic [SUM_W-1:0]     fwd_data_r;
  logic                 out_valid_r;
  logic [SUM_W-1:0]     out_sum_r;
  logic                 out_last_r;

  logic                 a_go;
  logic                 b_go;

  assign b_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !b_go;
  assign a_go     = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Position counters and per-channel row sums.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [RS_W-1:0]  rowsum_r [MAX_CHANNELS];
  logic [RS_W-1:0]  rowsum_nxt [MAX_CHANNELS];

  logic [COL_W-1:0]  col_eff;
  logic [ROW_W-1:0]  row_eff;
  logic [CH_W-1:0]   ch_eff;
  logic [RS_W-1:0]   rs_cur;
  logic [RS_W-1:0]   rs_new;
  logic [ADDR_W-1:0] a_addr;
  logic              a_last;
  logic              ch_wrap;
  logic              col_wrap;
  logic              row_wrap;

  // A frame start sends the positions home and clears the row sums first.
  assign col_eff = in_frame_start ? '0 : col_r;
  assign row_eff = in_frame_start ? '0 : row_r;
  assign ch_eff  = in_frame_start ? '0 : ch_r;
  assign rs_cur  = in_frame_start ? '0 : rowsum_r[ch_eff];
  assign rs_new  = rs_cur + RS_W'(in_pixel_value);
  assign a_addr  = ADDR_W'(32'(col_eff) * 32'(MAX_CHANNELS) + 32'(ch_eff));

  assign ch_wrap  = (32'(ch_eff) + 32'd1) >= 32'(nc_lim);
  assign col_wrap = (32'(col_eff) + 32'd1) >= 32'(w_lim);
  assign row_wrap = (32'(row_eff) + 32'd1) >= 32'(h_lim);

  assign a_last = (32'(row_eff) == 32'(h_lim) - 32'd1)
               && (32'(col_eff) == 32'(w_lim) - 32'd1)
               && (32'(ch_eff)  == 32'(nc_lim) - 32'd1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ch_nxt  = ch_r;
    for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
      rowsum_nxt[i] = rowsum_r[i];
    end
    if (a_go) begin
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        if (in_frame_start) begin
          rowsum_nxt[i] = '0;
        end
        if (CH_W'(i) == ch_eff) begin
          rowsum_nxt[i] = rs_new;
        end
      end
      col_nxt = col_eff;
      row_nxt = row_eff;
      ch_nxt  = ch_eff + CH_W'(1);
      if (ch_wrap) begin
        ch_nxt  = '0;
        col_nxt = col_eff + COL_W'(1);
        if (col_wrap) begin
          // Row finished: the running sums start over on the next row.
          col_nxt = '0;
          row_nxt = row_eff + ROW_W'(1);
          for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
            rowsum_nxt[i] = '0;
          end
          if (row_wrap) begin
            row_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ch_r  <= '0;
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        rowsum_r[i] <= '0;
      end
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ch_r  <= ch_nxt;
      for (int i = 0; i < int'(MAX_CHANNELS); i++) begin
        rowsum_r[i] <= rowsum_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line store: read at stage A, written back at stage B.
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0] ram_rd_data;
  logic [SUM_W-1:0] above;
  logic [SUM_W-1:0] b_sum;

  iib_line_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (SUM_W)
  ) u_line_ram (
    .clk     (clk),
    .rd_en   (a_go),
    .rd_addr (a_addr),
    .rd_data (ram_rd_data),
    .wr_en   (b_go),
    .wr_addr (s1_addr_r),
    .wr_data (b_sum)
  );

  // When the byte in stage B wrote the entry that the new byte reads in the
  // same cycle (one pixel wide, one channel), the memory returns stale data,
  // so the fresh sum is carried over in a bypass register instead.
  assign above = s1_row0_r ? '0 : (fwd_r ? fwd_data_r : ram_rd_data);
  assign b_sum = SUM_W'(s1_rowsum_r) + above;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (a_go) begin
      s1_valid_r <= 1'b1;
      fwd_r      <= b_go && (s1_addr_r == a_addr);
    end else if (b_go) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      s1_addr_r   <= a_addr;
      s1_rowsum_r <= rs_new;
      s1_row0_r   <= (row_eff == '0);
      s1_last_r   <= a_last;
      fwd_data_r  <= b_sum;
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_sum_r  <= b_sum;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_area_sum  = out_sum_r;
  assign out_frame_end = out_last_r;

`ifndef ASSERT_OFF
  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked byte in the summing stage");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    a_go |=> s1_valid_r)
    else $error("accepted byte did not reach the summing stage");

  a_stage_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    b_go |=> out_valid_r)
    else $error("summing stage moved but output register is empty");

  a_bypass_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("bypass flag set with no byte in the summing stage");

  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ch_r) < 32'(MAX_CHANNELS))
    else $error("channel position beyond the line store layout");
`endif

endmodule : integral_image_builder_core

`default_nettype wire

FILE: sv/iib_line_ram.sv
// Single-port-write, single-port-read line store with a registered read.
// Depends on nothing; instantiated by integral_image_builder_core.
`default_nettype none

module iib_line_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 28
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // A read in the same cycle as a write to that entry returns the old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : iib_line_ram

`default_nettype wire
